@@ sv/tls_record_deframer_unit_assert.svh @@
`ifndef TLS_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define TLS_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Flag a condition that must never hold out of reset.
`define TRD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Flag a broken implication out of reset.
`define TRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/trd_pkg.sv @@
package trd_pkg;

    localparam int HDR_BYTES  = 5;
    localparam int HST_W      = $clog2(HDR_BYTES - 1);
    localparam int HIDX_W     = $clog2(HDR_BYTES);
    localparam int LEN_W      = 17;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int TDATA_W    = 32;
    localparam int TUSER_W    = 3;

    localparam logic [15:0] SSL2_LEN_MASK = 16'h7FFF;
    localparam logic [LEN_W-1:0] SSL2_LEN_ADJ = LEN_W'(2);
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HDR_BYTES);

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic                          is_hdr;
        logic                          last;
        logic                          legacy;
        logic                          short_rec;
        logic [LEN_W-1:0]              total;
        logic [HDR_BYTES-1:0][7:0]     data;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

@@ sv/tls_record_deframer_unit.sv @@
// A body byte leaves through a queue entry and then the output register.
// A header leaves as HDR_BYTES words, all from the one queue entry pushed with its last byte.
// Throughput: one word per cycle in and out while m_tready is high; the input stalls only
// when the 4-entry queue fills. Reset: rst_n is asynchronous, active low; clears the byte
// count, length, format flag, queue pointers and output valid. Header bytes are not cleared.
module tls_record_deframer_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // in_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [trd_pkg::TDATA_W-1:0]  m_tdata,  // out_byte, rec_length, zero pad
    output logic                         m_tlast,  // rec_last
    output logic [trd_pkg::TUSER_W-1:0]  m_tuser   // rec_first, legacy_format, short_record
);
    import trd_pkg::*;

    fifo_stat_t stat;
    logic       push;
    logic       pop;
    entry_t     push_entry;
    entry_t     head;

    trd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .stat       (stat),
        .push       (push),
        .push_entry (push_entry)
    );

    trd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    trd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sv/trd_front.sv @@
module trd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // in_byte
    input  trd_pkg::fifo_stat_t stat,
    output logic               push,
    output trd_pkg::entry_t    push_entry
);
    import trd_pkg::*;

    logic [LEN_W-1:0]         byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]         record_total_reg, record_total_next;
    logic                     legacy_reg, legacy_next;
    logic [HDR_BYTES-2:0][7:0] hdr_reg;

    logic             accept;
    logic             in_hdr;
    logic             hdr_done;
    logic             dec_legacy;
    logic [LEN_W-1:0] dec_total;
    logic             body_last;
    logic [LEN_W:0]   count_inc;

    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;
    assign in_hdr   = byte_count_reg < HDR_LEN;
    assign hdr_done = byte_count_reg == LEN_W'(HDR_BYTES - 1);
    assign count_inc = {1'b0, byte_count_reg} + (LEN_W + 1)'(1);

    always_comb
    begin
        dec_legacy = hdr_reg[0][7];
        if (dec_legacy)
        begin
            dec_total = {1'b0, {hdr_reg[0], hdr_reg[1]} & SSL2_LEN_MASK} + SSL2_LEN_ADJ;
        end
        else
        begin
            dec_total = {1'b0, hdr_reg[HDR_BYTES-2], s_tdata} + HDR_LEN;
        end
    end

    assign body_last = count_inc >= {1'b0, record_total_reg};

    always_comb
    begin
        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            push_entry.data[i] = hdr_reg[i];
        end
        push_entry.data[HDR_BYTES-1] = s_tdata;
        if (in_hdr)
        begin
            push_entry.is_hdr    = 1'b1;
            push_entry.last      = dec_total <= HDR_LEN;
            push_entry.legacy    = dec_legacy;
            push_entry.short_rec = dec_total < HDR_LEN;
            push_entry.total     = dec_total;
        end
        else
        begin
            push_entry.data[0]   = s_tdata;
            push_entry.is_hdr    = 1'b0;
            push_entry.last      = body_last;
            push_entry.legacy    = legacy_reg;
            push_entry.short_rec = 1'b0;
            push_entry.total     = record_total_reg;
        end
    end

    assign push = accept && (!in_hdr || hdr_done);

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        record_total_next = record_total_reg;
        legacy_next       = legacy_reg;
        if (accept)
        begin
            if (in_hdr)
            begin
                if (hdr_done)
                begin
                    record_total_next = dec_total;
                    legacy_next       = dec_legacy;
                    byte_count_next   = (dec_total <= HDR_LEN) ? '0 : count_inc[LEN_W-1:0];
                end
                else
                begin
                    byte_count_next = count_inc[LEN_W-1:0];
                end
            end
            else
            begin
                byte_count_next = body_last ? '0 : count_inc[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            record_total_reg <= '0;
            legacy_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            record_total_reg <= record_total_next;
            legacy_reg       <= legacy_next;
        end
    end

    // hold header bytes until the header completes
    always_ff @(posedge clk)
    begin
        if (accept && in_hdr && !hdr_done)
        begin
            hdr_reg[byte_count_reg[HST_W-1:0]] <= s_tdata;
        end
    end

endmodule

@@ sv/trd_fifo.sv @@
`include "tls_record_deframer_unit_assert.svh"

module trd_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  trd_pkg::entry_t     push_entry,
    input  logic                pop,
    output trd_pkg::entry_t     head,
    output trd_pkg::fifo_stat_t stat
);
    import trd_pkg::*;

    entry_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign stat.full  = count_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign stat.empty = count_reg == '0;
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (FIFO_AW + 1)'(1);
            2'b01:   count_next = count_reg - (FIFO_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    `TRD_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && stat.full, "push into full queue")
    `TRD_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty, "pop from empty queue")
    `TRD_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > (FIFO_AW + 1)'(FIFO_DEPTH), "queue count out of range")

endmodule

@@ sv/trd_back.sv @@
`include "tls_record_deframer_unit_assert.svh"

module trd_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  trd_pkg::entry_t              head,
    input  trd_pkg::fifo_stat_t          stat,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [trd_pkg::TDATA_W-1:0]  m_tdata,  // out_byte, rec_length, zero pad
    output logic                         m_tlast,  // rec_last
    output logic [trd_pkg::TUSER_W-1:0]  m_tuser   // rec_first, legacy_format, short_record
);
    import trd_pkg::*;

    logic [HIDX_W-1:0]  hidx_reg, hidx_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;
    logic [TUSER_W-1:0] m_tuser_reg;

    logic   load;
    logic   seg_end;
    byte_t  sel_byte;
    logic   word_first;
    logic   word_last;
    logic   word_short;

    assign load     = (!m_tvalid_reg || m_tready) && !stat.empty;
    assign seg_end  = !head.is_hdr || hidx_reg == HIDX_W'(HDR_BYTES - 1);
    assign pop      = load && seg_end;
    assign sel_byte = head.is_hdr ? head.data[hidx_reg] : head.data[0];

    assign word_first = head.is_hdr && hidx_reg == '0;
    assign word_last  = head.last && seg_end;
    assign word_short = head.is_hdr && head.short_rec;

    always_comb
    begin
        hidx_next     = hidx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            hidx_next     = seg_end ? '0 : hidx_reg + HIDX_W'(1);
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            hidx_reg     <= hidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= {(TDATA_W - LEN_W - 8)'(0), head.total, sel_byte};
            m_tlast_reg <= word_last;
            m_tuser_reg <= {word_short, head.legacy, word_first};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `TRD_ASSERT_IMPLY(a_idx_idle_on_body, clk, rst_n, !stat.empty && !head.is_hdr, hidx_reg == '0, "header index left mid-burst")
    `TRD_ASSERT_NEVER(a_idx_range, clk, rst_n, hidx_reg > HIDX_W'(HDR_BYTES - 1), "header index out of range")

endmodule

@@ test/tb_tls_record_deframer_unit.sv @@
`timescale 1ns / 100ps

module tb_tls_record_deframer_unit;

    import trd_pkg::*;

    typedef struct {
        logic [7:0]       data;
        logic             first;
        logic             last;
        logic             legacy;
        logic [LEN_W-1:0] total;
        logic             cut;
    } rec_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic [TUSER_W-1:0]   m_tuser;

    logic [7:0]           stream_bytes[$];
    rec_word_t            want_words[$];

    logic [7:0]           hdr_held[HDR_BYTES];
    int                   rec_pos;
    logic [LEN_W-1:0]     rec_total;
    logic                 rec_legacy;

    int                   err_count;
    bit                   in_taken;
    bit                   in_calm;
    bit                   out_calm;
    int                   in_gap;
    int                   out_hold;

    tls_record_deframer_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    // Queue one record: random header content with the length field set, then body.
    task automatic push_record(input bit ssl2, input logic [15:0] len_field,
                               input int body_cap);
        logic [7:0]       hdr[HDR_BYTES];
        logic [LEN_W-1:0] total;
        int               body_n;
        for (int i = 0; i < HDR_BYTES; i++)
            hdr[i] = $urandom_range(0, 255);
        if (ssl2)
        begin
            hdr[0] = {1'b1, len_field[14:8]};
            hdr[1] = len_field[7:0];
            total  = LEN_W'(len_field[14:0]) + LEN_W'(2);
        end
        else
        begin
            hdr[0][7]           = 1'b0;
            hdr[HDR_BYTES - 2]  = len_field[15:8];
            hdr[HDR_BYTES - 1]  = len_field[7:0];
            total               = LEN_W'(len_field) + LEN_W'(HDR_BYTES);
        end
        body_n = (total > HDR_BYTES) ? int'(total) - HDR_BYTES : 0;
        if (body_n > body_cap)
            body_n = body_cap;
        for (int i = 0; i < HDR_BYTES; i++)
            stream_bytes.push_back(hdr[i]);
        for (int i = 0; i < body_n; i++)
            stream_bytes.push_back($urandom_range(0, 255));
    endtask

    function automatic void deframe_byte(input logic [7:0] b);
        rec_word_t w;
        logic      cut;
        if (rec_pos < HDR_BYTES)
        begin
            hdr_held[rec_pos] = b;
            rec_pos++;
            if (rec_pos == HDR_BYTES)
            begin
                if (hdr_held[0][7])
                begin
                    rec_legacy = 1'b1;
                    rec_total  = LEN_W'({hdr_held[0][6:0], hdr_held[1]}) + LEN_W'(2);
                end
                else
                begin
                    rec_legacy = 1'b0;
                    rec_total  = LEN_W'({hdr_held[HDR_BYTES - 2], hdr_held[HDR_BYTES - 1]})
                                 + LEN_W'(HDR_BYTES);
                end
                cut = (rec_total < HDR_BYTES);
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    w.data   = hdr_held[i];
                    w.first  = (i == 0);
                    w.last   = (i == HDR_BYTES - 1) && (rec_total <= HDR_BYTES);
                    w.legacy = rec_legacy;
                    w.total  = rec_total;
                    w.cut    = cut;
                    want_words.push_back(w);
                end
                if (rec_total <= HDR_BYTES)
                    rec_pos = 0;
            end
        end
        else
        begin
            w.data   = b;
            w.first  = 1'b0;
            w.last   = (rec_pos + 1 >= int'(rec_total));
            w.legacy = rec_legacy;
            w.total  = rec_total;
            w.cut    = 1'b0;
            want_words.push_back(w);
            rec_pos  = w.last ? 0 : rec_pos + 1;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if ($urandom_range(0, 63) == 0)
                in_calm = !in_calm;
            if (in_gap > 0)
            begin
                s_tvalid <= 1'b0;
                in_gap--;
            end
            else if (stream_bytes.size() != 0)
            begin
                s_tdata  <= stream_bytes.pop_front();
                s_tvalid <= 1'b1;
                if (!in_calm && $urandom_range(0, 2) == 0)
                    in_gap = idle_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                out_calm = !out_calm;
            if (out_hold > 0)
            begin
                m_tready <= 1'b0;
                out_hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!out_calm && $urandom_range(0, 3) == 0)
                    out_hold = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        rec_word_t w;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
            deframe_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_words.size() == 0)
            begin
                report_mismatch("unexpected word", m_tdata, 0);
            end
            else
            begin
                w = want_words.pop_front();
                if (m_tdata[7:0] !== w.data)
                    report_mismatch("out_byte", m_tdata[7:0], w.data);
                if (m_tdata[8 +: LEN_W] !== w.total)
                    report_mismatch("rec_length", m_tdata[8 +: LEN_W], w.total);
                if (m_tdata[TDATA_W-1:8+LEN_W] !== '0)
                    report_mismatch("tdata pad", m_tdata[TDATA_W-1:8+LEN_W], 0);
                if (m_tlast !== w.last)
                    report_mismatch("rec_last", m_tlast, w.last);
                if (m_tuser[0] !== w.first)
                    report_mismatch("rec_first", m_tuser[0], w.first);
                if (m_tuser[1] !== w.legacy)
                    report_mismatch("legacy_format", m_tuser[1], w.legacy);
                if (m_tuser[2] !== w.cut)
                    report_mismatch("short_record", m_tuser[2], w.cut);
            end
        end
    end

    initial
    begin
        int r;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        err_count = 0;
        in_taken  = 1'b0;
        in_calm   = 1'b0;
        out_calm  = 1'b0;
        in_gap    = 0;
        out_hold  = 0;
        rec_pos   = 0;
        rec_total = '0;
        rec_legacy = 1'b0;

        // zero-length record, short SSL2 record, SSL2 ending at the header, one-byte bodies
        push_record(1'b0, 16'h0000, 0);
        stream_bytes[0] = 8'h00;
        push_record(1'b1, 16'h0000, 0);
        push_record(1'b1, 16'h0003, 0);
        push_record(1'b0, 16'h0001, 1);
        stream_bytes[15] = 8'h7F;
        stream_bytes[stream_bytes.size() - 1] = 8'hFF;
        push_record(1'b1, 16'h0004, 1);

        while (stream_bytes.size() < 330)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                push_record(1'b0, 16'($urandom_range(0, 12)), 1 << 20);
            else if (r < 80)
                push_record(1'b1, 16'($urandom_range(0, 16)), 1 << 20);
            else if (r < 92)
                push_record(1'b0, 16'($urandom_range(13, 200)), 1 << 20);
            else
                push_record(1'b1, 16'($urandom_range(0, 4)), 1 << 20);
        end
        // largest length last; the record stays open after a few body words
        push_record(1'b0, 16'hFFFF, 4);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (want_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
